FILE: rtl/trps_pkg.sv
package trps_pkg;

   localparam int INTERVAL_WIDTH = 11;
   localparam int NODE_WIDTH = 12;
   localparam int DIFF_WIDTH = 33;
   localparam int DIV_STEPS = 33;
   localparam int DIV_COUNT_WIDTH = 6;

   typedef struct packed {
      logic signed [31:0] elevation;
      logic signed [31:0] position;
   } trps_req_type;

   typedef struct packed {
      logic signed [31:0]     slope;
      logic [NODE_WIDTH-1:0]  node_number;
      logic                   reach_side;
      logic                   divide_fault;
      logic                   profile_done;
   } trps_rsp_type;

   typedef struct packed {
      logic signed [31:0] quotient;
      logic               fault;
   } trps_div_type;

endpackage

FILE: rtl/trps_divider.sv
module trps_divider #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [trps_pkg::DIFF_WIDTH-1:0] numerator,
   input  logic signed [trps_pkg::DIFF_WIDTH-1:0] denominator,
   output logic                                  done,
   output trps_pkg::trps_div_type                result
);
   import trps_pkg::*;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_STEP = 2'd1;
   localparam logic [1:0] D_FIN  = 2'd2;

   logic [1:0]                 phase_ff, phase_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       done_ff, done_in;
   logic [32:0]                rem_ff, rem_in;
   logic [32:0]                bits_ff, bits_in;
   logic [32:0]                divisor_ff, divisor_in;
   logic                       negative_ff, negative_in;
   trps_div_type               result_ff, result_in;

   logic [32:0] mag_num;
   logic [32:0] mag_den;
   logic [63:0] scaled;
   logic [33:0] trial;
   logic [33:0] diff;
   logic        ge;
   logic        start_neg;

   assign mag_num = numerator[32] ? 33'(~numerator + 33'd1) : 33'(numerator);
   assign mag_den = denominator[32] ? 33'(~denominator + 33'd1) : 33'(denominator);
   assign scaled = {31'd0, mag_num} << FRACTION_BITS;
   assign start_neg = numerator[32] ^ denominator[32];
   assign trial = {rem_ff, bits_ff[32]};
   assign diff = trial - {1'b0, divisor_ff};
   assign ge = trial >= {1'b0, divisor_ff};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      bits_in = bits_ff;
      divisor_in = divisor_ff;
      negative_in = negative_ff;
      result_in = result_ff;
      case (phase_ff)
         D_IDLE: begin
            if (start) begin
               if (mag_den == 33'd0) begin
                  done_in = 1'b1;
                  result_in.fault = 1'b1;
                  if (mag_num == 33'd0) begin
                     result_in.quotient = 32'sd0;
                  end else if (numerator[32]) begin
                     result_in.quotient = 32'sh8000_0000;
                  end else begin
                     result_in.quotient = 32'sh7FFF_FFFF;
                  end
               end else if ({2'b00, scaled[63:33]} >= mag_den) begin
                  done_in = 1'b1;
                  result_in.fault = 1'b0;
                  result_in.quotient = start_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  rem_in = {2'b00, scaled[63:33]};
                  bits_in = scaled[32:0];
                  divisor_in = mag_den;
                  negative_in = start_neg;
                  count_in = DIV_COUNT_WIDTH'(DIV_STEPS);
                  phase_in = D_STEP;
               end
            end
         end
         D_STEP: begin
            rem_in = ge ? diff[32:0] : trial[32:0];
            bits_in = {bits_ff[31:0], ge};
            count_in = count_ff - DIV_COUNT_WIDTH'(1);
            if (count_ff == DIV_COUNT_WIDTH'(1)) begin
               phase_in = D_FIN;
            end
         end
         D_FIN: begin
            done_in = 1'b1;
            result_in.fault = 1'b0;
            if (!negative_ff) begin
               result_in.quotient = (bits_ff > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                               : $signed(bits_ff[31:0]);
            end else begin
               result_in.quotient = (bits_ff > 33'h0_8000_0000) ? 32'sh8000_0000
                                                               : $signed(32'(~bits_ff + 33'd1));
            end
            phase_in = D_IDLE;
         end
         default: begin
            phase_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= D_IDLE;
         count_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      bits_ff <= bits_in;
      divisor_ff <= divisor_in;
      negative_ff <= negative_in;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

FILE: rtl/two_reach_profile_slope_unit.sv
// A node's first word goes through the start state, the divider and the put state; the divider
// skips its steps when the spacing is zero or the quotient exceeds 33 bits, and an output stall
// delays the load. Throughput is set by the shared 33-step restoring divider: the input stalls
// until a node's last word is loaded; the first node of a profile has no slope and no stall.
// A finished word waits in the output register while the next node is accepted.
// Reset is synchronous: both interval registers return to 1, the window and the node count clear.
module two_reach_profile_slope_unit #(
   parameter int MAX_REACH_INTERVALS = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  trps_pkg::trps_req_type                  req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output trps_pkg::trps_rsp_type                  rsp_word,
   input  logic                                    csr_we,
   input  logic                                    csr_index,
   input  logic [trps_pkg::INTERVAL_WIDTH-1:0]     csr_wdata
);
   import trps_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_RUN   = 2'd2;
   localparam logic [1:0] S_PUT   = 2'd3;
   localparam logic [16:0] MAX_LIMIT = 17'(MAX_REACH_INTERVALS);

   function automatic logic [12:0] clamp_intervals(input logic [INTERVAL_WIDTH-1:0] v);
      logic [12:0] r;
      if (v == '0) begin
         r = 13'd1;
      end else if ({6'd0, v} > MAX_LIMIT) begin
         r = MAX_LIMIT[12:0];
      end else begin
         r = {2'b00, v};
      end
      return r;
   endfunction

   logic [1:0]                state_ff, state_in;
   logic                      job_ff, job_in;
   logic                      has_b_ff, has_b_in;
   logic [INTERVAL_WIDTH-1:0] first_ff, second_ff;
   logic [NODE_WIDTH-1:0]     count_ff, count_in;
   logic signed [31:0]        older_elev_ff, older_pos_ff, newer_elev_ff, newer_pos_ff;
   logic signed [32:0]        num_a_ff, den_a_ff, num_b_ff, den_b_ff;
   logic [NODE_WIDTH-1:0]     node_a_ff, node_b_ff;
   logic                      side_a_ff, side_b_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   trps_rsp_type              rsp_word_ff, rsp_word_in;

   logic         accept;
   logic         load;
   logic [12:0]  junction;
   logic [12:0]  last;
   logic [12:0]  n;
   logic [12:0]  prev;
   logic         use_newer;
   logic signed [31:0] eu_a, xu_a;
   logic signed [32:0] num_a, den_a, num_b, den_b;
   logic         div_start;
   logic         div_done;
   trps_div_type div_res;

   assign junction = clamp_intervals(first_ff) + 13'd1;
   assign last = junction + clamp_intervals(second_ff);
   assign prev = {1'b0, count_ff};
   assign n = prev + 13'd1;
   assign use_newer = (prev == 13'd1) || (prev == junction);
   assign eu_a = use_newer ? newer_elev_ff : older_elev_ff;
   assign xu_a = use_newer ? newer_pos_ff : older_pos_ff;
   assign num_a = 33'(eu_a) - 33'(req_word.elevation);
   assign den_a = 33'(req_word.position) - 33'(xu_a);
   assign num_b = 33'(newer_elev_ff) - 33'(req_word.elevation);
   assign den_b = 33'(req_word.position) - 33'(newer_pos_ff);

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign load = (state_ff == S_PUT) && (!rsp_valid_ff || !rsp_stall);
   assign div_start = (state_ff == S_START);

   trps_divider #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numerator(job_ff ? num_b_ff : num_a_ff),
      .denominator(job_ff ? den_b_ff : den_a_ff),
      .done(div_done),
      .result(div_res)
   );

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      has_b_in = has_b_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               has_b_in = (n == junction) || (n >= last);
               count_in = (n >= last) ? '0 : n[NODE_WIDTH-1:0];
               job_in = 1'b0;
               if (count_ff != '0) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            state_in = S_RUN;
         end
         S_RUN: begin
            if (div_done) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (load) begin
               if (!job_ff && has_b_ff) begin
                  job_in = 1'b1;
                  state_in = S_START;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.slope = div_res.quotient;
         rsp_word_in.divide_fault = div_res.fault;
         rsp_word_in.node_number = job_ff ? node_b_ff : node_a_ff;
         rsp_word_in.reach_side = job_ff ? side_b_ff : side_a_ff;
         rsp_word_in.profile_done = job_ff && side_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff <= 1'b0;
         has_b_ff <= 1'b0;
         count_ff <= '0;
         first_ff <= INTERVAL_WIDTH'(1);
         second_ff <= INTERVAL_WIDTH'(1);
         older_elev_ff <= '0;
         older_pos_ff <= '0;
         newer_elev_ff <= '0;
         newer_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         has_b_ff <= has_b_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index) begin
               second_ff <= csr_wdata;
            end else begin
               first_ff <= csr_wdata;
            end
         end
         if (accept) begin
            older_elev_ff <= newer_elev_ff;
            older_pos_ff <= newer_pos_ff;
            newer_elev_ff <= req_word.elevation;
            newer_pos_ff <= req_word.position;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (accept) begin
         num_a_ff <= num_a;
         den_a_ff <= den_a;
         num_b_ff <= num_b;
         den_b_ff <= den_b;
         node_a_ff <= count_ff;
         side_a_ff <= prev >= junction;
         node_b_ff <= n[NODE_WIDTH-1:0];
         side_b_ff <= n >= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_RUN))
      else $error("divider finished outside of a running division");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |=> (state_ff == S_RUN))
      else $error("division start did not lead to a running division");

   a_second_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START && job_ff) |-> has_b_ff)
      else $error("second slope started for a node that has none");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (load && job_ff && side_b_ff) |-> (count_ff == '0))
      else $error("profile end word issued while the node count is not cleared");

endmodule

FILE: verif/tb_two_reach_profile_slope_unit.sv
`timescale 1ns / 100ps

module tb_two_reach_profile_slope_unit;
   import trps_pkg::*;

   localparam int MAX_REACH_INTERVALS = 1024;
   localparam int FRACTION_BITS = 16;
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASE_NODES = 62;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int HOLD_SPACING = 170;
   localparam int PREDICTED = -1;
   localparam int DIRECTED_ROWS = 28;
   localparam logic CSR_FIRST_REACH = 1'b0;
   localparam logic CSR_SECOND_REACH = 1'b1;
   localparam trps_rsp_type NO_WORD = '0;

   typedef enum logic {ROW_NODE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic                       csr_sel;
      logic [INTERVAL_WIDTH-1:0]  csr_value;
      trps_req_type               word;
      int                         typed_count;
      trps_rsp_type               typed0;
      trps_rsp_type               typed1;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   trps_req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   trps_rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic csr_index = CSR_FIRST_REACH;
   logic [INTERVAL_WIDTH-1:0] csr_wdata = '0;

   logic [INTERVAL_WIDTH-1:0] first_reach_setting = 11'd1;
   logic [INTERVAL_WIDTH-1:0] second_reach_setting = 11'd1;
   logic signed [31:0] lag2_elevation = '0;
   logic signed [31:0] lag2_position = '0;
   logic signed [31:0] lag1_elevation = '0;
   logic signed [31:0] lag1_position = '0;
   int unsigned nodes_in_profile = 0;

   trps_rsp_type fresh_slopes[$];
   trps_rsp_type pending_slopes[$];
   logic signed [31:0] walk_elevation = '0;
   logic signed [31:0] walk_position = '0;
   int burst_left = 0;
   int nodes_accepted = 0;
   int failures = 0;
   int stall_mode = 0;
   int pattern_left = 0;
   int hold_cycles = 0;
   int next_hold_at = 130;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0002_0000, 32'sh0000_0000}, 0,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0001_0000, 32'sh0001_0000}, 2,
        '{32'sh0001_0000, 12'd1, 1'b0, 1'b0, 1'b0},
        '{32'sh0001_0000, 12'd2, 1'b0, 1'b0, 1'b0}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0000_0000, 32'sh0002_0000}, 2,
        '{32'sh0001_0000, 12'd2, 1'b1, 1'b0, 1'b0},
        '{32'sh0001_0000, 12'd3, 1'b1, 1'b0, 1'b1}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh7FFF_FFFF, 32'sh0000_0005}, 0,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh8000_0000, 32'sh0000_0005}, 2,
        '{32'sh7FFF_FFFF, 12'd1, 1'b0, 1'b1, 1'b0},
        '{32'sh7FFF_FFFF, 12'd2, 1'b0, 1'b1, 1'b0}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh8000_0000, 32'sh0000_0005}, 2,
        '{32'sh0000_0000, 12'd2, 1'b1, 1'b1, 1'b0},
        '{32'sh0000_0000, 12'd3, 1'b1, 1'b1, 1'b1}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh8000_0000, 32'sh8000_0000}, 0,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh7FFF_FFFF, 32'sh8000_0000}, 2,
        '{32'sh8000_0000, 12'd1, 1'b0, 1'b1, 1'b0},
        '{32'sh8000_0000, 12'd2, 1'b0, 1'b1, 1'b0}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 2,
        '{32'sh0000_0000, 12'd2, 1'b1, 1'b0, 1'b0},
        '{32'sh0000_0000, 12'd3, 1'b1, 1'b0, 1'b1}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh7FFF_FFFF, 32'sh0000_0000}, 0,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh8000_0000, 32'sh0000_0001}, 2,
        '{32'sh7FFF_FFFF, 12'd1, 1'b0, 1'b0, 1'b0},
        '{32'sh7FFF_FFFF, 12'd2, 1'b0, 1'b0, 1'b0}},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh7FFF_FFFF, 32'sh8000_0000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FIRST_REACH, 11'd2, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_SECOND_REACH, 11'd0, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0003_0000, 32'sh0001_0000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0002_8000, 32'sh0001_8000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0002_0000, 32'sh0003_0000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_SECOND_REACH, 11'd2, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0001_0000, 32'sh0003_8000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'shFFFF_0000, 32'sh0005_0000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FIRST_REACH, 11'd2047, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_SECOND_REACH, 11'd1024, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0000_0000, 32'sh0000_0000}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh0000_0001, 32'shFFFF_FFFF}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'sh1234_5678, 32'sh0000_0002}, PREDICTED,
        NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FIRST_REACH, 11'd0, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_SECOND_REACH, 11'd1, '{32'sh0, 32'sh0}, PREDICTED, NO_WORD, NO_WORD},
      '{ROW_NODE, CSR_FIRST_REACH, 11'd0, '{32'shEDCB_A988, 32'sh0000_8000}, PREDICTED,
        NO_WORD, NO_WORD}
   };

   two_reach_profile_slope_unit #(
      .MAX_REACH_INTERVALS(MAX_REACH_INTERVALS),
      .FRACTION_BITS(FRACTION_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int effective_intervals(input logic [INTERVAL_WIDTH-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_REACH_INTERVALS) return MAX_REACH_INTERVALS;
      return int'(value);
   endfunction

   function automatic trps_rsp_type slope_between(
      input logic signed [31:0] up_elevation, input logic signed [31:0] up_position,
      input logic signed [31:0] down_elevation, input logic signed [31:0] down_position,
      input int unsigned node, input logic side, input logic done);
      longint rise;
      longint span;
      longint quotient;
      trps_rsp_type word;
      rise = longint'(up_elevation) - longint'(down_elevation);
      span = longint'(down_position) - longint'(up_position);
      word.divide_fault = (span == 0);
      if (span == 0) begin
         quotient = (rise > 0) ? 64'sh7FFF_FFFF : ((rise < 0) ? -64'sh8000_0000 : 0);
      end else begin
         quotient = (rise * (longint'(1) << FRACTION_BITS)) / span;
         if (quotient > 64'sh7FFF_FFFF) quotient = 64'sh7FFF_FFFF;
         if (quotient < -64'sh8000_0000) quotient = -64'sh8000_0000;
      end
      word.slope = quotient[31:0];
      word.node_number = node[NODE_WIDTH-1:0];
      word.reach_side = side;
      word.profile_done = done;
      return word;
   endfunction

   task automatic predict_node(input trps_req_type word);
      int unsigned junction_node;
      int unsigned final_node;
      int unsigned n;
      junction_node = effective_intervals(first_reach_setting) + 1;
      final_node = junction_node + effective_intervals(second_reach_setting);
      n = nodes_in_profile + 1;
      fresh_slopes.delete();
      if (n > 1) begin
         if (n - 1 == 1) begin
            fresh_slopes.push_back(slope_between(lag1_elevation, lag1_position,
               word.elevation, word.position, n - 1, 1'b0, 1'b0));
         end else if (n - 1 == junction_node) begin
            fresh_slopes.push_back(slope_between(lag1_elevation, lag1_position,
               word.elevation, word.position, n - 1, 1'b1, 1'b0));
         end else begin
            fresh_slopes.push_back(slope_between(lag2_elevation, lag2_position,
               word.elevation, word.position, n - 1, (n - 1 > junction_node), 1'b0));
         end
      end
      if (n == junction_node) begin
         fresh_slopes.push_back(slope_between(lag1_elevation, lag1_position,
            word.elevation, word.position, n, 1'b0, 1'b0));
      end
      if (n >= final_node) begin
         fresh_slopes.push_back(slope_between(lag1_elevation, lag1_position,
            word.elevation, word.position, n, 1'b1, 1'b1));
         nodes_in_profile = 0;
      end else begin
         nodes_in_profile = n;
      end
      lag2_elevation = lag1_elevation;
      lag2_position = lag1_position;
      lag1_elevation = word.elevation;
      lag1_position = word.position;
   endtask

   // Mostly a smooth profile with rising positions; the rest repeats a position,
   // jumps anywhere, or steps backward.
   function automatic trps_req_type next_node();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         walk_position = walk_position + $urandom_range(1, 32'h0004_0000);
         walk_elevation = walk_elevation + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      end else if (pick < 78) begin
         walk_elevation = walk_elevation + $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
      end else if (pick < 90) begin
         walk_elevation = $urandom;
         walk_position = $urandom;
      end else begin
         walk_position = walk_position - $urandom_range(1, 32'h0010_0000);
      end
      return '{walk_elevation, walk_position};
   endfunction

   task automatic send_node(input trps_req_type word, input int typed_count,
                            input trps_rsp_type typed0, input trps_rsp_type typed1);
      int gap;
      req_valid <= 1'b1;
      req_word <= word;
      do @(posedge clock); while (req_stall);
      predict_node(word);
      if (typed_count == PREDICTED) begin
         foreach (fresh_slopes[i]) pending_slopes.push_back(fresh_slopes[i]);
      end else begin
         if (typed_count > 0) pending_slopes.push_back(typed0);
         if (typed_count > 1) pending_slopes.push_back(typed1);
      end
      nodes_accepted++;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(1, 15);
      end else begin
         burst_left--;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_slopes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input logic sel, input logic [INTERVAL_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_FIRST_REACH) begin
         first_reach_setting = value;
      end else begin
         second_reach_setting = value;
      end
   endtask

   task automatic check_field(input string name, input longint expected, input longint actual);
      if (expected != actual) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      trps_rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_slopes.size() == 0) begin
            failures++;
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_word);
         end else begin
            due = pending_slopes.pop_front();
            check_field("slope", due.slope, rsp_word.slope);
            check_field("node_number", due.node_number, rsp_word.node_number);
            check_field("reach_side", due.reach_side, rsp_word.reach_side);
            check_field("divide_fault", due.divide_fault, rsp_word.divide_fault);
            check_field("profile_done", due.profile_done, rsp_word.profile_done);
         end
      end
   end

   // The receiver follows random stall modes and now and then holds off for a
   // long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (nodes_accepted >= next_hold_at) begin
         rsp_stall <= 1'b1;
         hold_cycles <= LONG_HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_SPACING;
      end else begin
         if (pattern_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(4, 60);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 7) != 0);
            end
         endcase
      end
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_interval(directed_rows[i].csr_sel, directed_rows[i].csr_value);
         end else begin
            send_node(directed_rows[i].word, directed_rows[i].typed_count,
                      directed_rows[i].typed0, directed_rows[i].typed1);
         end
      end
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 3) begin
            // A long profile is cut short by shrinking both reaches mid-way.
            wait_idle();
            write_interval(CSR_FIRST_REACH, 11'd2047);
            wait_idle();
            write_interval(CSR_SECOND_REACH, 11'd1024);
            repeat (40) send_node(next_node(), PREDICTED, NO_WORD, NO_WORD);
            wait_idle();
            write_interval(CSR_FIRST_REACH, 11'd0);
            wait_idle();
            write_interval(CSR_SECOND_REACH, 11'd1);
            repeat (40) send_node(next_node(), PREDICTED, NO_WORD, NO_WORD);
         end else begin
            wait_idle();
            write_interval(CSR_FIRST_REACH, INTERVAL_WIDTH'($urandom_range(0, 10)));
            wait_idle();
            write_interval(CSR_SECOND_REACH, INTERVAL_WIDTH'($urandom_range(0, 10)));
            repeat (PHASE_NODES) send_node(next_node(), PREDICTED, NO_WORD, NO_WORD);
         end
      end
      wait_idle();
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
